// ===== sv/wrg_pkg.sv =====
// Shared types and constants of the waveform generator with ramp envelope.
package wrg_pkg;

  // Length and gain widths (gain 1.0 = 65536)
  localparam int LEN_W  = 16;
  localparam int GAIN_W = 17;
  localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

  // Request into the envelope gain divider
  typedef struct packed {
    logic             start;
    logic [LEN_W-1:0] pos;
    logic [LEN_W-1:0] den;
  } div_req_t;

  // Response from the envelope gain divider
  typedef struct packed {
    logic              done;
    logic [GAIN_W-1:0] gain;
  } div_rsp_t;

endpackage

// ===== sv/wrg_sine_rom.sv =====
// Sine lookup ROM in Q1.15, filled at elaboration, with registered read data.
module wrg_sine_rom #(
  parameter int DEPTH     = 1024,
  parameter int ADDR_BITS = 10
) (
  input  logic                 clk,
  input  logic [ADDR_BITS-1:0] addr,
  output logic signed [15:0]   data
);

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'h0000_0000_4000_0000;

  typedef logic signed [15:0] rom_t [DEPTH];

  // One entry: quarter-wave reduction, then Taylor series through x^11 in Q30
  function automatic logic signed [15:0] sine_entry(input int k);
    logic [63:0] u;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] prod;
    logic [63:0] sum;
    logic [63:0] q;
    logic [1:0]  quad;
    int          n;
    u    = (64'(k) << 32) / 64'(DEPTH);
    quad = u[31:30];
    r    = {34'd0, u[29:0]};
    if (quad[0]) begin
      r = ONE_Q30 - r;
    end
    x    = (r * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (n = 1; n <= 5; n++) begin
      prod = (term * x2) >> 30;
      case (n)
        1:       term = prod / 64'd6;
        2:       term = prod / 64'd20;
        3:       term = prod / 64'd42;
        4:       term = prod / 64'd72;
        default: term = prod / 64'd110;
      endcase
      if (n[0]) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    q = (sum * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return quad[1] ? -$signed(q[15:0]) : $signed(q[15:0]);
  endfunction

  function automatic rom_t build_rom();
    rom_t t;
    for (int k = 0; k < DEPTH; k++) begin
      t[k] = sine_entry(k);
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // Registered read
  always_ff @(posedge clk) begin
    data <= SINE_ROM[addr];
  end

endmodule

// ===== sv/wrg_divider.sv =====
// Radix-2 restoring divider for envelope gains: floor(pos * 65536 / den).
module wrg_divider (
  input  logic              clk,
  input  logic              rst,
  input  wrg_pkg::div_req_t req,
  output wrg_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(wrg_pkg::LEN_W + 1);

  logic                      busy;
  logic                      done;
  logic                      full;
  logic [CNT_W-1:0]          cnt;
  logic [wrg_pkg::LEN_W-1:0] rem;
  logic [wrg_pkg::LEN_W-1:0] quot;
  logic [wrg_pkg::LEN_W-1:0] den_q;
  logic [wrg_pkg::LEN_W:0]   rem_sh;
  logic [wrg_pkg::LEN_W:0]   diff;
  logic                      fits;
  logic                      no_ramp;

  // Gain is 1.0 with no ramp or once past the ramp
  assign no_ramp = (req.den == '0) || (req.pos >= req.den);

  // One quotient bit per cycle
  assign rem_sh = {rem, 1'b0};
  assign diff   = rem_sh - {1'b0, den_q};
  assign fits   = rem_sh >= {1'b0, den_q};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        if (no_ramp) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt  <= CNT_W'(wrg_pkg::LEN_W);
        end
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      full  <= no_ramp;
      rem   <= req.pos;
      den_q <= req.den;
      quot  <= '0;
    end else if (busy) begin
      rem  <= fits ? diff[wrg_pkg::LEN_W-1:0] : rem_sh[wrg_pkg::LEN_W-1:0];
      quot <= {quot[wrg_pkg::LEN_W-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.gain = full ? wrg_pkg::GAIN_ONE : {1'b0, quot};

endmodule

// ===== sv/waveform_generator_with_ramp_core.sv =====
// Note generator top: phase accumulator, wave shaping, shared multiplier and envelope sequencer.
// A playing note's request passes load, shape, multiply, up-gain, down-gain, multiply, multiply,
// saturate and output before its sample shows on m_axis_tvalid; each gain is unity past the ramp
// and comes from the one-bit-per-cycle divider inside it. With no note playing: load, then output.
// Throughput: one request at a time; s_axis_tready returns once the sample is registered.
// Reset (rst, synchronous): phase, sample index and note state cleared, registers to defaults.
module waveform_generator_with_ramp_core #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int PHASE_BITS       = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] start_note, [7:1] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] sample_out (signed)
  output logic        m_axis_tlast,   // note_end
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AB = $clog2(SINE_TABLE_DEPTH);
  localparam int IW = PHASE_BITS + AB;
  localparam int LW = wrg_pkg::LEN_W;
  localparam int GW = wrg_pkg::GAIN_W;

  // Register indexes
  localparam logic [2:0] REG_WAVE_SHAPE  = 3'd0;
  localparam logic [2:0] REG_PHASE_STEP  = 3'd1;
  localparam logic [2:0] REG_PEAK_LEVEL  = 3'd2;
  localparam logic [2:0] REG_RAMP_LENGTH = 3'd3;
  localparam logic [2:0] REG_NOTE_LENGTH = 3'd4;

  // Wave shapes
  localparam logic [1:0] SHAPE_SINE   = 2'd0;
  localparam logic [1:0] SHAPE_TRI    = 2'd1;
  localparam logic [1:0] SHAPE_RECT   = 2'd2;
  localparam logic [1:0] SHAPE_SQUARE = 2'd3;

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_SHAPE = 4'd2;
  localparam logic [3:0] S_MULPW = 4'd3;
  localparam logic [3:0] S_DIVUP = 4'd4;
  localparam logic [3:0] S_DIVDN = 4'd5;
  localparam logic [3:0] S_MULG  = 4'd6;
  localparam logic [3:0] S_MULM  = 4'd7;
  localparam logic [3:0] S_SAT   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0]            state;
  logic [3:0]            state_next;

  logic [1:0]            wave_shape;
  logic [31:0]           phase_step;
  logic [14:0]           peak_level;
  logic [LW-1:0]         ramp_length;
  logic [LW-1:0]         note_length;

  logic [PHASE_BITS-1:0] phase;
  logic [LW-1:0]         sample_index;
  logic                  note_active;

  logic                  in_acc;
  logic                  out_load;
  logic                  out_valid;
  logic [15:0]           out_data;
  logic                  out_last;

  logic [LW-1:0]         last_idx;
  logic                  is_end;
  logic [LW-1:0]         rem_c;
  logic [LW-1:0]         rem_q;
  logic                  end_q;

  logic [IW-1:0]         idx_full;
  logic signed [15:0]    rom_q;

  logic [15:0]           tri_p;
  logic [15:0]           tri_d;
  logic [16:0]           tri_2d;
  logic                  tri_neg;
  logic [15:0]           tri_mag;
  logic                  tv_neg;
  logic                  tv_pos;
  logic [15:0]           tv_mag;
  logic [15:0]           shp_mag;
  logic                  shp_neg;
  logic [15:0]           wmag;
  logic                  wneg;

  logic [30:0]           mul_a;
  logic [GW-1:0]         mul_b;
  logic                  mul_en;
  logic [47:0]           prod;
  logic [30:0]           m_q;
  logic [GW-1:0]         gain_up;
  logic [GW-1:0]         gain_dn;

  logic [16:0]           mag;
  logic [16:0]           mag_neg;
  logic [15:0]           sat_data;
  logic [15:0]           res_data;
  logic                  res_last;

  wrg_pkg::div_req_t     div_req;
  wrg_pkg::div_rsp_t     div_rsp;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign out_load      = (state == S_OUT) && (!out_valid || m_axis_tready);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      wave_shape  <= SHAPE_SINE;
      phase_step  <= 32'd39370534;
      peak_level  <= 15'd10000;
      ramp_length <= 16'd4800;
      note_length <= 16'd48000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WAVE_SHAPE:  wave_shape  <= cfg_data[1:0];
        REG_PHASE_STEP:  phase_step  <= cfg_data;
        REG_PEAK_LEVEL:  peak_level  <= cfg_data[14:0];
        REG_RAMP_LENGTH: ramp_length <= cfg_data[LW-1:0];
        REG_NOTE_LENGTH: note_length <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_acc) state_next = S_LOAD;
      S_LOAD:  state_next = note_active ? S_SHAPE : S_OUT;
      S_SHAPE: state_next = S_MULPW;
      S_MULPW: state_next = S_DIVUP;
      S_DIVUP: if (div_rsp.done) state_next = S_DIVDN;
      S_DIVDN: if (div_rsp.done) state_next = S_MULG;
      S_MULG:  state_next = S_MULM;
      S_MULM:  state_next = S_SAT;
      S_SAT:   state_next = S_OUT;
      S_OUT:   if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Note state: restart on a start_note request, advance when the sample is handed out
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= '0;
      sample_index <= '0;
      note_active  <= 1'b0;
    end else if (in_acc && s_axis_tdata[0]) begin
      phase        <= '0;
      sample_index <= '0;
      note_active  <= 1'b1;
    end else if (out_load && note_active) begin
      phase        <= phase + PHASE_BITS'(phase_step);
      sample_index <= sample_index + LW'(1);
      if (res_last) begin
        note_active <= 1'b0;
      end
    end
  end

  // Note position; a zero note length acts as one
  assign last_idx = (note_length == '0) ? '0 : note_length - LW'(1);
  assign is_end   = sample_index >= last_idx;
  assign rem_c    = is_end ? '0 : last_idx - sample_index;

  always_ff @(posedge clk) begin
    if (state == S_LOAD) begin
      end_q <= is_end;
      rem_q <= rem_c;
    end
  end

  // Table address from the phase
  assign idx_full = IW'(phase) * IW'(SINE_TABLE_DEPTH);

  wrg_sine_rom #(
    .DEPTH     (SINE_TABLE_DEPTH),
    .ADDR_BITS (AB)
  ) u_rom (
    .clk  (clk),
    .addr (idx_full[IW-1:PHASE_BITS]),
    .data (rom_q)
  );

  // Triangle from the top 16 phase bits: 32768 - 2*|p - 32768|
  assign tri_p   = phase[PHASE_BITS-1 -: 16];
  assign tri_d   = tri_p[15] ? {1'b0, tri_p[14:0]} : 16'h8000 - tri_p;
  assign tri_2d  = {tri_d, 1'b0};
  assign tri_neg = tri_2d > 17'h08000;
  assign tri_mag = tri_neg ? 16'(tri_2d - 17'h08000) : 16'(17'h08000 - tri_2d);

  // Table value as sign and magnitude
  assign tv_neg = rom_q[15];
  assign tv_pos = !tv_neg && (rom_q != 16'sd0);
  assign tv_mag = tv_neg ? (~rom_q + 16'd1) : rom_q;

  always_comb begin
    case (wave_shape)
      SHAPE_SINE: begin
        shp_mag = tv_mag;
        shp_neg = tv_neg;
      end
      SHAPE_TRI: begin
        shp_mag = tri_mag;
        shp_neg = tri_neg;
      end
      SHAPE_RECT: begin
        shp_mag = tv_pos ? rom_q : 16'd0;
        shp_neg = 1'b0;
      end
      SHAPE_SQUARE: begin
        shp_mag = 16'h8000;
        shp_neg = !tv_pos;
      end
      default: begin
        shp_mag = 16'd0;
        shp_neg = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_SHAPE) begin
      wmag <= shp_mag;
      wneg <= shp_neg;
    end
  end

  // Shared multiplier: peak*|w|, then gain_up*gain_dn, then m*g
  always_comb begin
    mul_en = 1'b1;
    case (state)
      S_MULPW: begin
        mul_a = 31'(peak_level);
        mul_b = GW'(wmag);
      end
      S_MULG: begin
        mul_a = 31'(gain_up);
        mul_b = gain_dn;
      end
      S_MULM: begin
        mul_a = m_q;
        mul_b = prod[32:16];
      end
      default: begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= 48'(mul_a) * 48'(mul_b);
    end
  end

  // Envelope gains through the shared divider
  assign div_req.start = (state == S_MULPW) || ((state == S_DIVUP) && div_rsp.done);
  assign div_req.pos   = (state == S_MULPW) ? sample_index : rem_q;
  assign div_req.den   = ramp_length;

  wrg_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (state == S_DIVUP) begin
      m_q <= prod[30:0];
      if (div_rsp.done) begin
        gain_up <= div_rsp.gain;
      end
    end
    if ((state == S_DIVDN) && div_rsp.done) begin
      gain_dn <= div_rsp.gain;
    end
  end

  // Scale down by 2^31 and saturate
  assign mag      = prod[47:31];
  assign mag_neg  = (mag > 17'h08000) ? 17'h08000 : mag;
  assign sat_data = wneg ? 16'(17'h10000 - mag_neg)
                         : ((mag > 17'h07FFF) ? 16'h7FFF : mag[15:0]);

  always_ff @(posedge clk) begin
    if (state == S_LOAD && !note_active) begin
      res_data <= 16'd0;
      res_last <= 1'b0;
    end else if (state == S_SAT) begin
      res_data <= sat_data;
      res_last <= end_q;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= res_data;
      out_last <= res_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tlast  = out_last;

  // Checks
  a_div_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIVUP || state == S_DIVDN))
    else $error("divider finished outside a gain step");

  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (div_rsp.gain <= wrg_pkg::GAIN_ONE))
    else $error("envelope gain above unity");

  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    (state != S_OUT && !in_acc) |=> $stable(phase))
    else $error("phase moved outside a sample hand-off");

  a_note_ends: assert property (@(posedge clk) disable iff (rst)
    (out_load && res_last) |=> !note_active)
    else $error("note still active after its last sample");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the note generator: notes, wave shapes, envelope and stalls.
module testbench;

  typedef enum logic [1:0] {
    SHAPE_SINE      = 2'd0,
    SHAPE_TRIANGLE  = 2'd1,
    SHAPE_RECTIFIED = 2'd2,
    SHAPE_SQUARE    = 2'd3
  } shape_t;

  // Register indexes of the write port
  localparam logic [2:0] REG_WAVE_SHAPE  = 3'd0;
  localparam logic [2:0] REG_PHASE_STEP  = 3'd1;
  localparam logic [2:0] REG_PEAK_LEVEL  = 3'd2;
  localparam logic [2:0] REG_RAMP_LENGTH = 3'd3;
  localparam logic [2:0] REG_NOTE_LENGTH = 3'd4;

  localparam int TABLE_DEPTH   = 1024;
  localparam int TABLE_BITS    = 10;
  localparam int SETTLE_CYCLES = 50;   // beyond the worst sample latency
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 1600;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned Q30_ONE     = 64'd1 << 30;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               note_end;
  } sample_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;    // [0] start_note, [7:1] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [15:0] sample_out (signed)
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [31:0] cfg_data = 32'd0;

  waveform_generator_with_ramp_core u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Generator state mirrored by the testbench
  int              sine_tab [TABLE_DEPTH];
  logic [31:0]     gen_phase;
  logic [15:0]     gen_index;
  logic            gen_active;
  shape_t          cur_shape;
  logic [31:0]     cur_step;
  logic [14:0]     cur_peak;
  logic [15:0]     cur_ramp;
  logic [15:0]     cur_len;

  sample_t         pending_samples [$];
  int              error_count;
  int              requests_sent;
  int              samples_checked;
  bit              tx_idle;
  bit              rx_idle;
  int              rx_hold;
  int              rx_gap;
  sample_t         rx_want;

  // Table entry: quarter-wave reduction then a Q30 Taylor series through x^11
  function automatic int sine_entry(input int unsigned k);
    longint unsigned kk, u, r, x, x2, term, sum, q, div;
    int unsigned quad;
    int unsigned n;
    kk = 64'(k);
    u = (kk << 32) / TABLE_DEPTH;
    quad = 32'((u >> 30) & 3);
    r = u & (Q30_ONE - 1);
    if (quad & 1)
      r = Q30_ONE - r;
    x = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    for (n = 1; n <= 5; n++) begin
      div = 64'((2 * n) * (2 * n + 1));
      term = ((term * x2) >> 30) / div;
      if (n & 1)
        sum = (sum >= term) ? sum - term : 64'd0;
      else
        sum = sum + term;
    end
    q = (sum * 32767 + (Q30_ONE >> 1)) >> 30;
    if (q > 32767)
      q = 32767;
    return (quad >= 2) ? -int'(q) : int'(q);
  endfunction

  // Linear envelope gain, 1.0 = 65536
  function automatic longint envelope_gain(input int unsigned pos);
    longint lpos;
    lpos = longint'(pos);
    if (cur_ramp == 0 || pos >= cur_ramp)
      return 65536;
    return (lpos << 16) / cur_ramp;
  endfunction

  // Next output sample for one request; advances the mirrored state
  function automatic sample_t compute_sample(input logic start);
    sample_t     res;
    int unsigned last_idx, remain, tidx;
    int          tv, w, p, d;
    longint      v, m, g, mag;
    bit          at_end, neg;
    if (start) begin
      gen_phase = 32'd0;
      gen_index = 16'd0;
      gen_active = 1'b1;
    end
    if (!gen_active) begin
      res.sample = 16'sd0;
      res.note_end = 1'b0;
      return res;
    end
    last_idx = (cur_len == 0) ? 0 : cur_len - 1;
    at_end = (gen_index >= last_idx);
    remain = at_end ? 0 : last_idx - gen_index;
    tidx = gen_phase >> (32 - TABLE_BITS);
    tv = sine_tab[tidx];
    case (cur_shape)
      SHAPE_SINE: w = tv;
      SHAPE_TRIANGLE: begin
        p = int'(gen_phase[31:16]);
        d = p - 32768;
        if (d < 0)
          d = -d;
        w = 32768 - 2 * d;
      end
      SHAPE_RECTIFIED: w = (tv > 0) ? tv : 0;
      default: w = (tv > 0) ? 32768 : -32768;
    endcase
    v = longint'(cur_peak) * w;
    neg = (v < 0);
    m = neg ? -v : v;
    g = (envelope_gain(gen_index) * envelope_gain(remain)) >> 16;
    mag = (m * g) >> 31;
    if (neg) begin
      if (mag > 32768)
        mag = 32768;
      res.sample = -mag[15:0];
    end else begin
      if (mag > 32767)
        mag = 32767;
      res.sample = mag[15:0];
    end
    res.note_end = at_end;
    gen_phase = gen_phase + cur_step;
    gen_index = gen_index + 16'd1;
    if (at_end)
      gen_active = 1'b0;
    return res;
  endfunction

  // Append one expected sample to the scoreboard
  task automatic enqueue_expected(input sample_t want);
    pending_samples = {pending_samples, want};
  endtask

  // Offer one request; tvalid is only lowered before an idle gap
  task automatic send_request(input logic start);
    int gap;
    gap = tx_idle ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, start};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    enqueue_expected(compute_sample(start));
    requests_sent++;
  endtask

  // Stop offering and let every outstanding sample come back
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [2:0] index, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
  endtask

  // Write all five registers while the block is idle
  task automatic configure(input shape_t shape, input logic [31:0] step,
                           input logic [14:0] peak, input logic [15:0] ramp,
                           input logic [15:0] len);
    wait_idle();
    put_reg(REG_WAVE_SHAPE, {30'd0, shape});
    put_reg(REG_PHASE_STEP, step);
    put_reg(REG_PEAK_LEVEL, {17'd0, peak});
    put_reg(REG_RAMP_LENGTH, {16'd0, ramp});
    put_reg(REG_NOTE_LENGTH, {16'd0, len});
    cfg_we <= 1'b0;
    cur_shape = shape;
    cur_step = step;
    cur_peak = peak;
    cur_ramp = ramp;
    cur_len = len;
  endtask

  task automatic random_config();
    shape_t      shape;
    logic [31:0] step;
    logic [14:0] peak;
    logic [15:0] ramp, len;
    shape = shape_t'($urandom_range(0, 3));
    case ($urandom_range(0, 7))
      0: step = 32'd0;
      1: step = 32'hFFFF_FFFF;
      2: step = $urandom_range(1, 4096);
      default: step = $urandom;
    endcase
    case ($urandom_range(0, 7))
      0: peak = 15'd0;
      1: peak = 15'h7FFF;
      default: peak = 15'($urandom);
    endcase
    case ($urandom_range(0, 15))
      0: len = 16'd0;
      1: len = 16'hFFFF;
      2: len = 16'd1;
      default: len = 16'($urandom_range(2, 40));
    endcase
    case ($urandom_range(0, 7))
      0: ramp = 16'd0;
      1: ramp = 16'hFFFF;
      default: ramp = (len > 16'd1000) ? 16'($urandom)
                                       : 16'($urandom_range(1, int'(len) + 2));
    endcase
    configure(shape, step, peak, ramp, len);
  endtask

  // Receiver: check each accepted sample, then stall at random or on a long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_samples.size() == 0) begin
          $display("%0t: unexpected sample %0d, nothing expected", $time,
                   $signed(m_axis_tdata));
          error_count++;
        end else begin
          rx_want = pending_samples.pop_front();
          if (m_axis_tdata !== rx_want.sample) begin
            $display("%0t: sample_out mismatch, expected %0d, actual %0d", $time,
                     rx_want.sample, $signed(m_axis_tdata));
            error_count++;
          end
          if (m_axis_tlast !== rx_want.note_end) begin
            $display("%0t: note_end mismatch, expected %0b, actual %0b", $time,
                     rx_want.note_end, m_axis_tlast);
            error_count++;
          end
        end
        samples_checked++;
        rx_gap = rx_idle ? $urandom_range(0, 3) : 0;
      end
      if (rx_hold > 0) begin
        rx_hold = rx_hold - 1;
        m_axis_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap = rx_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Reset values: silence first, then the start of a default note
  task automatic test_reset_defaults();
    send_request(1'b0);
    send_request(1'b1);
    repeat (2) send_request(1'b0);
  endtask

  // Quarter-cycle steps land on the table zeros and peaks of every shape at full level
  task automatic test_shapes();
    shape_t shape;
    int     s;
    for (s = 0; s < 4; s++) begin
      shape = shape_t'(s);
      configure(shape, 32'h4000_0000, 15'h7FFF, 16'd0, 16'd4);
      send_request(1'b1);
      repeat (3) send_request(1'b0);
    end
  endtask

  // Zero length acts as one; a one-sample note, then silence
  task automatic test_short_notes();
    configure(SHAPE_SQUARE, 32'hFFFF_FFFF, 15'h7FFF, 16'd0, 16'd0);
    send_request(1'b1);
    configure(SHAPE_SINE, 32'hFFFF_FFFF, 15'd0, 16'd0, 16'd1);
    send_request(1'b1);
    send_request(1'b0);
  endtask

  // Note length cut below the current index mid-note ends it on the next sample
  task automatic test_shortened_note();
    configure(SHAPE_TRIANGLE, 32'h0123_4567, 15'd20000, 16'd4, 16'd10);
    send_request(1'b1);
    repeat (3) send_request(1'b0);
    configure(SHAPE_TRIANGLE, 32'h0123_4567, 15'd20000, 16'd4, 16'd2);
    send_request(1'b0);
    send_request(1'b0);
  endtask

  // Long receiver hold-off with the sender offering back to back, then a pause mid-note
  task automatic test_backpressure();
    configure(SHAPE_SINE, $urandom, 15'h7FFF, 16'hFFFF, 16'hFFFF);
    tx_idle = 1'b0;
    rx_hold = HOLD_CYCLES;
    send_request(1'b1);
    repeat (19) send_request(1'b0);
    wait_idle();
    tx_idle = 1'b1;
    repeat (5) send_request(1'b0);
  endtask

  // Mostly well-formed notes with random settings; some noise and interrupted notes
  task automatic test_random_notes(input int target);
    int burst;
    int stop_at;
    stop_at = requests_sent + target;
    while (requests_sent < stop_at) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      if (gen_active && $urandom_range(0, 1)) begin
        // carry on with an open note, often under new settings
        if ($urandom_range(0, 1))
          random_config();
        repeat ($urandom_range(1, 20)) send_request(1'b0);
      end else begin
        random_config();
        if ($urandom_range(0, 7) != 0) begin
          burst = (cur_len <= 1) ? 1 : int'(cur_len);
          if (burst > 60)
            burst = $urandom_range(10, 60);
          send_request(1'b1);
          repeat (burst - 1) send_request($urandom_range(0, 31) == 0);
          repeat ($urandom_range(0, 2)) send_request(1'b0);
        end else begin
          repeat ($urandom_range(1, 16)) send_request($urandom_range(0, 3) == 0);
        end
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    int k;
    for (k = 0; k < TABLE_DEPTH; k++)
      sine_tab[k] = sine_entry(k);
    gen_phase = 32'd0;
    gen_index = 16'd0;
    gen_active = 1'b0;
    cur_shape = SHAPE_SINE;
    cur_step = 32'd39370534;
    cur_peak = 15'd10000;
    cur_ramp = 16'd4800;
    cur_len = 16'd48000;
    error_count = 0;
    requests_sent = 0;
    samples_checked = 0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    rx_hold = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_shapes();
    test_short_notes();
    test_shortened_note();
    test_backpressure();
    test_random_notes(RANDOM_ITEMS);
    wait_idle();

    $display("Run covered %0d requests and %0d checked samples: all wave shapes,", requests_sent,
             samples_checked);
    $display("envelope ramps, zero and full lengths, shortened notes, restarts and stalls.");
    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Timeout with %0d samples outstanding", pending_samples.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/wrg_pkg.sv
sv/wrg_sine_rom.sv
sv/wrg_divider.sv
sv/waveform_generator_with_ramp_core.sv
tb/testbench.sv
